FILE: hw/rtl/ipv6rfc_pkg.sv
// Package for the IPv6 receive frame classifier: word types, verdict codes,
// header offsets and the checksum and address-byte helper functions.
// Depends on nothing.
package ipv6rfc_pkg;

    typedef enum logic [4:0] {
        V_NOT_IPV6       = 5'd0,
        V_SHORT          = 5'd1,
        V_BAD_VERSION    = 5'd2,
        V_LEN_MISMATCH   = 5'd3,
        V_NOT_FOR_ME     = 5'd4,
        V_ICMP_CSUM_ZERO = 5'd5,
        V_ICMP_CSUM_BAD  = 5'd6,
        V_NDP_LEN        = 5'd7,
        V_NDP_CODE       = 5'd8,
        V_NDP_NOT_ME     = 5'd9,
        V_NDP_SOLICIT    = 5'd10,
        V_ECHO_REQ       = 5'd11,
        V_ICMP_OTHER     = 5'd12,
        V_UDP_SHORT      = 5'd13,
        V_UDP_CSUM_ZERO  = 5'd14,
        V_UDP_CSUM_BAD   = 5'd15,
        V_UDP_LEN_BAD    = 5'd16,
        V_UDP_TOO_SHORT  = 5'd17,
        V_UDP_OK         = 5'd18,
        V_OTHER_HEADER   = 5'd19
    } verdict_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  icmp_type;
        logic [15:0] udp_src_port;
        logic [15:0] udp_dst_port;
        logic [10:0] payload_length;
        logic [47:0] sender_mac;
    } out_word_t;

    typedef struct packed {
        logic ver;
        logic etype;
        logic pend;
        logic over;
        logic tgt_bad;
        logic not_all;
        logic not_snm;
        logic not_ll;
    } hdr_flags_t;

    localparam int unsigned OFS_SRC_MAC  = 6;
    localparam int unsigned OFS_ETYPE_HI = 12;
    localparam int unsigned OFS_ETYPE_LO = 13;
    localparam int unsigned OFS_VERSION  = 14;
    localparam int unsigned OFS_PLEN_HI  = 18;
    localparam int unsigned OFS_PLEN_LO  = 19;
    localparam int unsigned OFS_NEXT_HDR = 20;
    localparam int unsigned OFS_SRC_IP   = 22;
    localparam int unsigned OFS_DST_IP   = 38;
    localparam int unsigned OFS_PAYLOAD  = 54;

    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] ICMP_NS      = 8'd135;
    localparam logic [7:0] ICMP_ECHO    = 8'd128;

    function automatic logic [16:0] fold_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input int unsigned i);
        return mac[8*(5-i) +: 8];
    endfunction

    function automatic logic [7:0] ll_byte(input logic [3:0] i, input logic [47:0] mac);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'hFE;
            4'd1:    r = 8'h80;
            4'd8:    r = mac_byte(mac, 0) ^ 8'h02;
            4'd9:    r = mac_byte(mac, 1);
            4'd10:   r = mac_byte(mac, 2);
            4'd11:   r = 8'hFF;
            4'd12:   r = 8'hFE;
            4'd13:   r = mac_byte(mac, 3);
            4'd14:   r = mac_byte(mac, 4);
            4'd15:   r = mac_byte(mac, 5);
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] snm_byte(input logic [3:0] i, input logic [47:0] mac);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'hFF;
            4'd1:    r = 8'h02;
            4'd11:   r = 8'h01;
            4'd12:   r = 8'hFF;
            4'd13:   r = mac_byte(mac, 3);
            4'd14:   r = mac_byte(mac, 4);
            4'd15:   r = mac_byte(mac, 5);
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] all_byte(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'hFF;
            4'd1:    r = 8'h02;
            4'd15:   r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/ipv6rfc_if.sv
// Valid/ready channel interfaces for frame bytes in and verdicts out.
// Depends on ipv6rfc_pkg.
interface ipv6rfc_in_if import ipv6rfc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ipv6rfc_out_if import ipv6rfc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ipv6_receive_frame_classifier.sv
// Top level of the IPv6 receive frame classifier.
// Depends on ipv6rfc_pkg and the channel interfaces in ipv6rfc_if.sv.
//
//  channel | dir | word                          | taken when
//  rx      | in  | frame_byte, last_byte         | rx.valid && rx.ready
//  tx      | out | verdict, icmp_type, ports,    | tx.valid && tx.ready
//          |     | payload_length, sender_mac    |
//  apb     | in  | own_mac at paddr[3] == 0      | psel && penable && pwrite
//
// One byte is taken per cycle while rx.ready is high. After its last byte, a
// frame's updated state is captured by the snapshot stage, then the verdict
// logic fills the output register from that snapshot.
// Reset clears frame state, the sender cache and own_mac; no clearing pass.
// A stalled tx holds the output register; rx stays ready while the snapshot
// stage is empty or can move on.
module ipv6_receive_frame_classifier import ipv6rfc_pkg::*; #(
    parameter int MAX_FRAME = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ipv6rfc_in_if.sink           rx,
    ipv6rfc_out_if.source        tx,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

    // Configuration
    logic [47:0] own_mac_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? {16'd0, own_mac_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= 48'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[3] == 1'b0)
        begin
            own_mac_reg <= pwdata[47:0];
        end
    end

    // Per-frame state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]      acc_reg, acc_next;
    logic [7:0]       ph_reg, ph_next;
    hdr_flags_t       flags_reg, flags_next;
    logic [15:0]      plen_reg, plen_next;
    logic [7:0]       nh_reg, nh_next;
    logic [63:0]      tp_reg, tp_next;
    logic [47:0]      smac_reg, smac_next;

    // Snapshot stage
    logic             s2_valid_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic [16:0]      s2_acc_reg;
    logic [7:0]       s2_ph_reg;
    hdr_flags_t       s2_flags_reg;
    logic [15:0]      s2_plen_reg;
    logic [7:0]       s2_nh_reg;
    logic [63:0]      s2_tp_reg;
    logic [47:0]      s2_smac_reg;

    // Output stage
    logic             out_valid_reg;
    out_word_t        out_reg, out_next;
    logic [47:0]      cache_mac_reg, cache_mac_next;

    logic out_free, rx_take, s2_move;
    logic [7:0] b;
    logic [CNT_W-1:0] k;
    logic [3:0] dst_i, tgt_i;
    logic do_sum;
    logic [CNT_W-1:0] csum_skip;

    assign out_free = !out_valid_reg || tx.ready;
    assign s2_move  = s2_valid_reg && out_free;
    assign rx.ready = !s2_valid_reg || out_free;
    assign rx_take  = rx.valid && rx.ready;
    assign b        = rx.data.frame_byte;
    assign k        = cnt_reg - CNT_W'(OFS_PAYLOAD);
    assign dst_i    = 4'(cnt_reg - CNT_W'(OFS_DST_IP));
    assign tgt_i    = 4'(k - CNT_W'(8));
    assign csum_skip = (nh_reg == PROTO_UDP) ? CNT_W'(6) : CNT_W'(2);

    // Fold one byte into the header state
    always_comb
    begin
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        flags_next = flags_reg;
        plen_next  = plen_reg;
        nh_next    = nh_reg;
        tp_next    = tp_reg;
        smac_next  = smac_reg;
        do_sum     = 1'b0;
        if (cnt_reg == CNT_MAX)
        begin
            flags_next.over = 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg >= CNT_W'(OFS_SRC_MAC) && cnt_reg < CNT_W'(OFS_ETYPE_HI))
            begin
                smac_next = {smac_reg[39:0], b};
            end
            else if (cnt_reg == CNT_W'(OFS_ETYPE_HI))
            begin
                if (b != 8'h86) flags_next.etype = 1'b1;
            end
            else if (cnt_reg == CNT_W'(OFS_ETYPE_LO))
            begin
                if (b != 8'hDD) flags_next.etype = 1'b1;
            end
            else if (cnt_reg == CNT_W'(OFS_VERSION))
            begin
                if ((b & 8'hF0) != 8'h60) flags_next.ver = 1'b1;
            end
            else if (cnt_reg == CNT_W'(OFS_PLEN_HI) || cnt_reg == CNT_W'(OFS_PLEN_LO))
            begin
                plen_next = {plen_reg[7:0], b};
            end
            else if (cnt_reg == CNT_W'(OFS_NEXT_HDR))
            begin
                nh_next = b;
            end
            else if (cnt_reg >= CNT_W'(OFS_SRC_IP) && cnt_reg < CNT_W'(OFS_PAYLOAD))
            begin
                do_sum = 1'b1;
                if (cnt_reg >= CNT_W'(OFS_DST_IP))
                begin
                    if (b != ll_byte(dst_i, own_mac_reg))  flags_next.not_ll  = 1'b1;
                    if (b != snm_byte(dst_i, own_mac_reg)) flags_next.not_snm = 1'b1;
                    if (b != all_byte(dst_i))              flags_next.not_all = 1'b1;
                end
            end
            else if (cnt_reg >= CNT_W'(OFS_PAYLOAD) && 16'(k) < plen_reg)
            begin
                if (k < CNT_W'(8))
                begin
                    tp_next[8*(7-int'(k[2:0])) +: 8] = b;
                end
                if (nh_reg == PROTO_ICMPV6 && k >= CNT_W'(8) && k < CNT_W'(24)
                    && b != ll_byte(tgt_i, own_mac_reg))
                begin
                    flags_next.tgt_bad = 1'b1;
                end
                // skip the stored checksum
                if (k != csum_skip && k != csum_skip + CNT_W'(1)) do_sum = 1'b1;
            end
            if (do_sum)
            begin
                if (!cnt_reg[0])
                begin
                    ph_next = b;
                    flags_next.pend = 1'b1;
                end
                else
                begin
                    acc_next = fold_add(acc_reg, {ph_reg, b});
                    flags_next.pend = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            acc_reg   <= '0;
            ph_reg    <= '0;
            flags_reg <= '0;
            plen_reg  <= '0;
            nh_reg    <= '0;
            tp_reg    <= '0;
            smac_reg  <= '0;
        end
        else if (rx_take)
        begin
            if (rx.data.last_byte)
            begin
                // drop frame state, the snapshot carries it on
                cnt_reg   <= '0;
                acc_reg   <= '0;
                ph_reg    <= '0;
                flags_reg <= '0;
                plen_reg  <= '0;
                nh_reg    <= '0;
                tp_reg    <= '0;
                smac_reg  <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                ph_reg    <= ph_next;
                flags_reg <= flags_next;
                plen_reg  <= plen_next;
                nh_reg    <= nh_next;
                tp_reg    <= tp_next;
                smac_reg  <= smac_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (rx_take && rx.data.last_byte)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take && rx.data.last_byte)
        begin
            s2_cnt_reg   <= cnt_next;
            s2_acc_reg   <= acc_next;
            s2_ph_reg    <= ph_next;
            s2_flags_reg <= flags_next;
            s2_plen_reg  <= plen_next;
            s2_nh_reg    <= nh_next;
            s2_tp_reg    <= tp_next;
            s2_smac_reg  <= smac_next;
        end
    end

    // Verdict from the snapshot
    logic [16:0] cs0, cs1, cs2, cs3, cs4;
    logic [15:0] stored, stored_eff, ulen;
    logic        csum_ok, hdr_short, hdr_good;
    logic [15:0] tail_len;

    assign stored     = (s2_nh_reg == PROTO_ICMPV6) ? s2_tp_reg[47:32] : s2_tp_reg[15:0];
    assign stored_eff = (stored == 16'hFFFF) ? 16'd0 : stored;
    assign ulen       = s2_tp_reg[31:16];
    assign tail_len   = 16'(s2_cnt_reg - CNT_W'(OFS_PAYLOAD));

    always_comb
    begin
        cs0 = s2_flags_reg.pend ? fold_add(s2_acc_reg, {s2_ph_reg, 8'h00}) : s2_acc_reg;
        cs1 = fold_add(cs0, s2_plen_reg);
        cs2 = fold_add(cs1, {8'h00, s2_nh_reg});
        cs3 = fold_add(cs2, stored_eff);
        cs4 = {1'b0, cs3[15:0]} + {16'd0, cs3[16]};
        csum_ok = ({1'b0, cs4[15:0]} + {16'd0, cs4[16]}) == 17'h0FFFF;
    end

    assign hdr_short = s2_flags_reg.over || s2_cnt_reg < CNT_W'(OFS_PAYLOAD);
    assign hdr_good  = !hdr_short && !s2_flags_reg.etype && !s2_flags_reg.ver
                       && !(s2_plen_reg > tail_len)
                       && !(s2_flags_reg.not_ll && s2_flags_reg.not_snm
                            && s2_flags_reg.not_all);

    always_comb
    begin
        out_next = '0;
        cache_mac_next = hdr_good ? s2_smac_reg : cache_mac_reg;
        if (hdr_short)                          out_next.verdict = V_SHORT;
        else if (s2_flags_reg.etype)            out_next.verdict = V_NOT_IPV6;
        else if (s2_flags_reg.ver)              out_next.verdict = V_BAD_VERSION;
        else if (s2_plen_reg > tail_len)        out_next.verdict = V_LEN_MISMATCH;
        else if (!hdr_good)                     out_next.verdict = V_NOT_FOR_ME;
        else if (s2_nh_reg == PROTO_ICMPV6)
        begin
            out_next.icmp_type      = s2_tp_reg[63:56];
            out_next.payload_length = s2_plen_reg[10:0];
            if (stored == 16'd0)                out_next.verdict = V_ICMP_CSUM_ZERO;
            else if (!csum_ok)                  out_next.verdict = V_ICMP_CSUM_BAD;
            else if (s2_tp_reg[63:56] == ICMP_NS)
            begin
                if (s2_plen_reg < 16'd24)       out_next.verdict = V_NDP_LEN;
                else if (s2_tp_reg[55:48] != 8'd0) out_next.verdict = V_NDP_CODE;
                else if (s2_flags_reg.tgt_bad)  out_next.verdict = V_NDP_NOT_ME;
                else                            out_next.verdict = V_NDP_SOLICIT;
            end
            else if (s2_tp_reg[63:56] == ICMP_ECHO) out_next.verdict = V_ECHO_REQ;
            else                                out_next.verdict = V_ICMP_OTHER;
        end
        else if (s2_nh_reg == PROTO_UDP)
        begin
            if (s2_plen_reg < 16'd8)            out_next.verdict = V_UDP_SHORT;
            else if (stored == 16'd0)           out_next.verdict = V_UDP_CSUM_ZERO;
            else if (!csum_ok)                  out_next.verdict = V_UDP_CSUM_BAD;
            else if (ulen < 16'd8)              out_next.verdict = V_UDP_LEN_BAD;
            else if (ulen > s2_plen_reg)        out_next.verdict = V_UDP_TOO_SHORT;
            else
            begin
                out_next.verdict        = V_UDP_OK;
                out_next.udp_src_port   = s2_tp_reg[63:48];
                out_next.udp_dst_port   = s2_tp_reg[47:32];
                out_next.payload_length = 11'(ulen - 16'd8);
            end
        end
        else                                    out_next.verdict = V_OTHER_HEADER;
        out_next.sender_mac = cache_mac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cache_mac_reg <= 48'd0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg) cache_mac_reg <= cache_mac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move) out_reg <= out_next;
    end

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_reg;

endmodule

FILE: hw/rtl/ipv6rfc_checker.sv
// Port-level checks for the IPv6 receive frame classifier, bound to the top.
// Depends on ipv6rfc_pkg.
module ipv6rfc_checker import ipv6rfc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      tx_valid,
    input logic      tx_ready,
    input out_word_t tx_data,
    input logic      pready
);

    // hold a stalled word
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_data))
        else $error("tx word changed while stalled");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> tx_data.verdict <= V_OTHER_HEADER)
        else $error("verdict code out of range");

    a_ports_udp_only: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_data.verdict != V_UDP_OK
        |-> tx_data.udp_src_port == 16'd0 && tx_data.udp_dst_port == 16'd0)
        else $error("ports given without udp_ok");

    a_icmp_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_data.verdict < V_ICMP_CSUM_ZERO
                     || tx_data.verdict > V_ICMP_OTHER)
        |-> tx_data.icmp_type == 8'd0)
        else $error("icmp type given for a non-ICMPv6 verdict");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind ipv6_receive_frame_classifier ipv6rfc_checker u_ipv6rfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_data  (tx.data),
    .pready   (pready)
);

FILE: dv/testbench.sv
// Testbench for the IPv6 receive frame classifier: builds frames byte by byte,
// predicts each verdict and checks every output word against it.
// Depends on ipv6rfc_pkg, the channel interfaces and the classifier top level.
`timescale 1ns / 1ps

module testbench;
    import ipv6rfc_pkg::*;

    // Destination address kinds for the frame builder
    localparam int DST_LL   = 0;
    localparam int DST_SNM  = 1;
    localparam int DST_ALL  = 2;
    localparam int DST_RAND = 3;

    // Checksum handling in the frame builder
    localparam int CS_GOOD = 0;
    localparam int CS_ZERO = 1;
    localparam int CS_BAD  = 2;

    localparam int FRAME_LIMIT = 2048;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    ipv6rfc_in_if  rx_ch ();
    ipv6rfc_out_if tx_ch ();

    ipv6_receive_frame_classifier #(.MAX_FRAME(FRAME_LIMIT)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .tx      (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Classifier state as predicted by the testbench
    // ------------------------------------------------------------------
    logic [47:0] station_mac;
    int          bytes_seen;
    int unsigned fold_sum;
    logic [7:0]  odd_byte;
    hdr_flags_t  flags;
    logic [15:0] ip_len;
    logic [7:0]  next_hdr;
    logic [63:0] l4_head;
    logic [47:0] src_mac;
    logic [47:0] last_sender_mac;

    out_word_t   verdict_q[$];   // expected verdict words, oldest first
    byte unsigned frm[$];        // frame under construction
    int          words_checked;
    int          errors;
    bit          idle_on;        // random idling on both sides
    int          hold_cycles;    // long receiver hold-off, counted down by the receiver

    function automatic int unsigned add_fold(int unsigned s, logic [15:0] w);
        int unsigned t;
        t = s + w;
        return (t & 32'hFFFF) + (t >> 16);
    endfunction

    // Station addresses as 128-bit vectors, first wire byte in the top bits
    function automatic logic [127:0] link_local_addr();
        return {16'hFE80, 48'h0, station_mac[47:40] ^ 8'h02, station_mac[39:24],
                16'hFFFE, station_mac[23:0]};
    endfunction

    function automatic logic [127:0] solicited_addr();
        return {16'hFF02, 72'h0, 8'h01, 8'hFF, station_mac[23:0]};
    endfunction

    function automatic logic [7:0] addr_at(logic [127:0] a, int i);
        return a[127 - 8*i -: 8];
    endfunction

    function automatic void clear_frame_state();
        bytes_seen = 0;
        fold_sum   = 0;
        odd_byte   = '0;
        flags      = '0;
        ip_len     = '0;
        next_hdr   = '0;
        l4_head    = '0;
        src_mac    = '0;
    endfunction

    function automatic void sum_in(int o, logic [7:0] b);
        if ((o & 1) == 0) begin
            odd_byte   = b;
            flags.pend = 1'b1;
        end
        else begin
            fold_sum   = add_fold(fold_sum, {odd_byte, b});
            flags.pend = 1'b0;
        end
    endfunction

    function automatic void absorb_byte(int o, logic [7:0] b);
        int k;
        int c;
        logic [127:0] all_nodes;
        all_nodes = {16'hFF02, 104'h0, 8'h01};
        if (o >= 6 && o < 12)
            src_mac = {src_mac[39:0], b};
        else if (o == 12) begin
            if (b != 8'h86) flags.etype = 1'b1;
        end
        else if (o == 13) begin
            if (b != 8'hDD) flags.etype = 1'b1;
        end
        else if (o == 14) begin
            if ((b & 8'hF0) != 8'h60) flags.ver = 1'b1;
        end
        else if (o == 18 || o == 19)
            ip_len = {ip_len[7:0], b};
        else if (o == 20)
            next_hdr = b;
        else if (o >= 22 && o < 54) begin
            sum_in(o, b);
            if (o >= 38) begin
                if (b != addr_at(link_local_addr(), o - 38)) flags.not_ll  = 1'b1;
                if (b != addr_at(solicited_addr(), o - 38))  flags.not_snm = 1'b1;
                if (b != addr_at(all_nodes, o - 38))         flags.not_all = 1'b1;
            end
        end
        else if (o >= 54) begin
            k = o - 54;
            c = (next_hdr == PROTO_UDP) ? 6 : 2;
            if (k >= int'(ip_len)) return;
            if (k < 8) l4_head[8*(7-k) +: 8] = b;
            if (next_hdr == PROTO_ICMPV6 && k >= 8 && k < 24
                && b != addr_at(link_local_addr(), k - 8))
                flags.tgt_bad = 1'b1;
            if (k != c && k != c + 1) sum_in(o, b);
        end
    endfunction

    function automatic bit checksum_ok(logic [7:0] proto, logic [15:0] stored);
        int unsigned s;
        s = fold_sum;
        if (flags.pend) s = add_fold(s, {odd_byte, 8'h00});
        s = add_fold(s, ip_len);
        s = add_fold(s, {8'h00, proto});
        s = add_fold(s, (stored == 16'hFFFF) ? 16'h0000 : stored);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return s == 32'hFFFF;
    endfunction

    // Advance the prediction by one accepted word; queue a verdict on the last byte
    function automatic void predict_word(logic [7:0] b, logic last);
        out_word_t   w;
        int          n;
        logic [7:0]  code;
        logic [15:0] stored;
        logic [15:0] udp_len;
        verdict_t    v;
        if (bytes_seen >= FRAME_LIMIT)
            flags.over = 1'b1;
        else
        begin
            absorb_byte(bytes_seen, b);
            bytes_seen++;
        end
        if (!last) return;
        w = '0;
        n = int'(ip_len);
        if (flags.over || bytes_seen < 54)
            v = V_SHORT;
        else if (flags.etype)
            v = V_NOT_IPV6;
        else if (flags.ver)
            v = V_BAD_VERSION;
        else if (n > bytes_seen - 54)
            v = V_LEN_MISMATCH;
        else if (flags.not_ll && flags.not_snm && flags.not_all)
            v = V_NOT_FOR_ME;
        else
        begin
            last_sender_mac = src_mac;
            if (next_hdr == PROTO_ICMPV6) begin
                code   = l4_head[55:48];
                stored = l4_head[47:32];
                w.icmp_type      = l4_head[63:56];
                w.payload_length = n[10:0];
                if (stored == 16'h0)                     v = V_ICMP_CSUM_ZERO;
                else if (!checksum_ok(PROTO_ICMPV6, stored)) v = V_ICMP_CSUM_BAD;
                else if (w.icmp_type == ICMP_NS) begin
                    if (n < 24)            v = V_NDP_LEN;
                    else if (code != 8'h0) v = V_NDP_CODE;
                    else if (flags.tgt_bad) v = V_NDP_NOT_ME;
                    else                   v = V_NDP_SOLICIT;
                end
                else if (w.icmp_type == ICMP_ECHO) v = V_ECHO_REQ;
                else                               v = V_ICMP_OTHER;
            end
            else if (next_hdr == PROTO_UDP) begin
                stored  = l4_head[15:0];
                udp_len = l4_head[31:16];
                if (n < 8)                              v = V_UDP_SHORT;
                else if (stored == 16'h0)               v = V_UDP_CSUM_ZERO;
                else if (!checksum_ok(PROTO_UDP, stored)) v = V_UDP_CSUM_BAD;
                else if (udp_len < 16'd8)               v = V_UDP_LEN_BAD;
                else if (int'(udp_len) > n)             v = V_UDP_TOO_SHORT;
                else
                begin
                    v = V_UDP_OK;
                    w.udp_src_port   = l4_head[63:48];
                    w.udp_dst_port   = l4_head[47:32];
                    w.payload_length = 11'(udp_len - 16'd8);
                end
            end
            else
                v = V_OTHER_HEADER;
        end
        w.verdict    = v;
        w.sender_mac = last_sender_mac;
        verdict_q.push_back(w);
        clear_frame_state();
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit, receiver and checker
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: a long hold-off takes priority, otherwise short random stalls
    initial
    begin
        int burst;
        burst = 0;
        tx_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                tx_ch.ready = 1'b0;
            end
            else
            begin
                if (idle_on && burst == 0 && $urandom_range(0, 7) == 0)
                    burst = $urandom_range(1, 7);
                if (burst > 0) begin
                    burst--;
                    tx_ch.ready = 1'b0;
                end
                else
                    tx_ch.ready = 1'b1;
            end
        end
    end

    // Checker: compare every accepted word with the oldest prediction
    initial
    begin
        out_word_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_ch.valid && tx_ch.ready) begin
                words_checked++;
                if (verdict_q.size() == 0) begin
                    $error("verdict word with none expected: %p", tx_ch.data);
                    errors++;
                end
                else
                begin
                    e = verdict_q.pop_front();
                    if (tx_ch.data.verdict !== e.verdict) begin
                        $error("verdict: expected %s, got %0d", e.verdict.name(),
                               tx_ch.data.verdict);
                        errors++;
                    end
                    if (tx_ch.data.icmp_type !== e.icmp_type) begin
                        $error("icmp_type: expected %0d, got %0d", e.icmp_type,
                               tx_ch.data.icmp_type);
                        errors++;
                    end
                    if (tx_ch.data.udp_src_port !== e.udp_src_port) begin
                        $error("udp_src_port: expected %0h, got %0h", e.udp_src_port,
                               tx_ch.data.udp_src_port);
                        errors++;
                    end
                    if (tx_ch.data.udp_dst_port !== e.udp_dst_port) begin
                        $error("udp_dst_port: expected %0h, got %0h", e.udp_dst_port,
                               tx_ch.data.udp_dst_port);
                        errors++;
                    end
                    if (tx_ch.data.payload_length !== e.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               e.payload_length, tx_ch.data.payload_length);
                        errors++;
                    end
                    if (tx_ch.data.sender_mac !== e.sender_mac) begin
                        $error("sender_mac: expected %0h, got %0h", e.sender_mac,
                               tx_ch.data.sender_mac);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task is entered and left just after a falling edge
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then advance the prediction
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 7);
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.data  = {b, last};
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        predict_word(b, last);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frm[i])
            send_word(frm[i], i == frm.size() - 1);
        rx_ch.valid = 1'b0;
    endtask

    // Hold the sender until every verdict has come, then let the pipeline settle
    task automatic drain();
        while (verdict_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_station_mac(input logic [47:0] mac);
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = 4'd0;
        pwdata  = {16'h0, mac};
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        station_mac = mac;
    endtask

    // Build a well-formed IPv6 frame into frm; fields may be spoilt afterwards
    task automatic build_frame(input int dst_kind, input logic [7:0] nh,
                               input logic [7:0] itype, input int plen,
                               input int cs_mode, input logic [7:0] code,
                               input int udp_len, input bit tgt_ok);
        logic [127:0] dst;
        int unsigned  s;
        logic [15:0]  cs;
        int           c;
        frm.delete();
        for (int i = 0; i < 12; i++) frm.push_back(8'($urandom_range(0, 255)));
        frm.push_back(8'h86);
        frm.push_back(8'hDD);
        frm.push_back(8'h60 | 8'($urandom_range(0, 15)));
        for (int i = 0; i < 3; i++) frm.push_back(8'($urandom_range(0, 255)));
        frm.push_back(8'(plen >> 8));
        frm.push_back(8'(plen));
        frm.push_back(nh);
        frm.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 16; i++) frm.push_back(8'($urandom_range(0, 255)));
        case (dst_kind)
            DST_LL:  dst = link_local_addr();
            DST_SNM: dst = solicited_addr();
            DST_ALL: dst = {16'hFF02, 104'h0, 8'h01};
            default: dst = {$urandom, $urandom, $urandom, $urandom};
        endcase
        for (int i = 0; i < 16; i++) frm.push_back(addr_at(dst, i));
        for (int i = 0; i < plen; i++) frm.push_back(8'($urandom_range(0, 255)));
        c = (nh == PROTO_UDP) ? 6 : 2;
        if (nh == PROTO_ICMPV6) begin
            if (plen > 0) frm[54] = itype;
            if (plen > 1) frm[55] = code;
            if (itype == ICMP_NS && tgt_ok)
                for (int k = 8; k < 24 && k < plen; k++)
                    frm[54 + k] = addr_at(link_local_addr(), k - 8);
        end
        if (nh == PROTO_UDP && plen > 5) begin
            frm[58] = 8'(udp_len >> 8);
            frm[59] = 8'(udp_len);
        end
        if (plen > c + 1) begin
            frm[54 + c] = 8'h00;
            frm[55 + c] = 8'h00;
            s = 0;
            for (int i = 22; i < 54; i += 2) s += {frm[i], frm[i + 1]};
            for (int k = 0; k < plen; k += 2)
                s += {frm[54 + k], (k + 1 < plen) ? frm[55 + k] : 8'h00};
            s += plen;
            s += nh;
            s = (s & 32'hFFFF) + (s >> 16);
            s = (s & 32'hFFFF) + (s >> 16);
            s = (s & 32'hFFFF) + (s >> 16);
            cs = ~s[15:0];
            if (cs == 16'h0) cs = 16'hFFFF;
            if (cs_mode == CS_ZERO) cs = 16'h0;
            else if (cs_mode == CS_BAD) cs = cs ^ 16'h0100;
            frm[54 + c] = cs[15:8];
            frm[55 + c] = cs[7:0];
        end
    endtask

    task automatic random_good_frame();
        int          pick;
        logic [7:0]  nh;
        logic [7:0]  it;
        int          plen;
        int          ul;
        pick = $urandom_range(0, 9);
        nh = (pick < 5) ? PROTO_ICMPV6 : (pick < 9) ? PROTO_UDP : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 3);
        it = (pick == 0) ? ICMP_NS : (pick == 1) ? ICMP_ECHO : 8'($urandom_range(0, 255));
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
        ul = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : plen;
        pick = $urandom_range(0, 9);
        build_frame($urandom_range(0, 9) == 0 ? DST_RAND : $urandom_range(DST_LL, DST_ALL),
                    nh, it, plen, pick == 0 ? CS_ZERO : pick == 1 ? CS_BAD : CS_GOOD,
                    $urandom_range(0, 5) == 0 ? 8'($urandom_range(1, 255)) : 8'h00,
                    ul, $urandom_range(0, 5) != 0);
        // Occasionally pad past the IP payload
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 10)) frm.push_back(8'($urandom_range(0, 255)));
    endtask

    // Broken or meaningless frames
    task automatic random_noise_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 4);
        random_good_frame();
        case (pick)
            0: begin
                n = $urandom_range(1, 80);
                frm.delete();
                repeat (n) frm.push_back(8'($urandom_range(0, 255)));
            end
            1: frm[12 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            2: frm[14] ^= 8'($urandom_range(1, 15) << 4);
            3: begin
                n = $urandom_range(1, frm.size());
                frm = frm[0:n - 1];
            end
            default: frm[$urandom_range(0, frm.size() - 1)] ^= 8'($urandom_range(1, 255));
        endcase
    endtask

    // Recompute the UDP checksum after the ports were overwritten
    task automatic build_frame_fix_udp();
        int unsigned s;
        logic [15:0] cs;
        int          plen;
        plen = int'({frm[18], frm[19]});
        frm[60] = 8'h00;
        frm[61] = 8'h00;
        s = 0;
        for (int i = 22; i < 54; i += 2) s += {frm[i], frm[i + 1]};
        for (int k = 0; k < plen; k += 2)
            s += {frm[54 + k], (k + 1 < plen) ? frm[55 + k] : 8'h00};
        s += plen + PROTO_UDP;
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        cs = ~s[15:0];
        if (cs == 16'h0) cs = 16'hFFFF;
        frm[60] = cs[15:8];
        frm[61] = cs[7:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_destinations();
        build_frame(DST_LL, PROTO_ICMPV6, ICMP_ECHO, 8, CS_GOOD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_SNM, PROTO_ICMPV6, ICMP_ECHO, 8, CS_GOOD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_ALL, 8'd6, 8'h00, 4, CS_GOOD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_RAND, PROTO_ICMPV6, ICMP_ECHO, 8, CS_GOOD, 8'h00, 0, 1);
        send_frame();
    endtask

    task automatic test_header_errors();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 12, CS_GOOD, 8'h00, 12, 1);
        frm = frm[0:52];
        send_frame();                                   // one byte short of a header
        build_frame(DST_LL, PROTO_UDP, 8'h00, 12, CS_GOOD, 8'h00, 12, 1);
        frm[12] = 8'h08;
        send_frame();                                   // not IPv6
        build_frame(DST_LL, PROTO_UDP, 8'h00, 12, CS_GOOD, 8'h00, 12, 1);
        frm[14] = 8'h45;
        send_frame();                                   // wrong version
        build_frame(DST_LL, PROTO_UDP, 8'h00, 12, CS_GOOD, 8'h00, 12, 1);
        void'(frm.pop_back());
        send_frame();                                   // payload cut short
        // Oversize frame: counter saturates, bytes dropped
        build_frame(DST_LL, PROTO_UDP, 8'h00, 12, CS_GOOD, 8'h00, 12, 1);
        while (frm.size() < FRAME_LIMIT + 10) frm.push_back(8'($urandom_range(0, 255)));
        send_frame();
    endtask

    task automatic test_icmp();
        build_frame(DST_LL, PROTO_ICMPV6, ICMP_ECHO, 16, CS_ZERO, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_LL, PROTO_ICMPV6, ICMP_ECHO, 16, CS_BAD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_SNM, PROTO_ICMPV6, ICMP_NS, 20, CS_GOOD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_SNM, PROTO_ICMPV6, ICMP_NS, 24, CS_GOOD, 8'hFF, 0, 1);
        send_frame();
        build_frame(DST_SNM, PROTO_ICMPV6, ICMP_NS, 24, CS_GOOD, 8'h00, 0, 0);
        send_frame();
        build_frame(DST_SNM, PROTO_ICMPV6, ICMP_NS, 32, CS_GOOD, 8'h00, 0, 1);
        send_frame();
        build_frame(DST_ALL, PROTO_ICMPV6, 8'hFF, 7, CS_GOOD, 8'h00, 0, 1);
        send_frame();                                   // odd length
    endtask

    task automatic test_udp();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 7, CS_GOOD, 8'h00, 7, 1);
        send_frame();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 20, CS_ZERO, 8'h00, 20, 1);
        send_frame();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 20, CS_BAD, 8'h00, 20, 1);
        send_frame();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 20, CS_GOOD, 8'h00, 7, 1);
        send_frame();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 20, CS_GOOD, 8'h00, 21, 1);
        send_frame();
        build_frame(DST_LL, PROTO_UDP, 8'h00, 8, CS_GOOD, 8'h00, 8, 1);
        send_frame();
        build_frame(DST_ALL, PROTO_UDP, 8'h00, 33, CS_GOOD, 8'h00, 30, 1);
        frm[54] = 8'hFF; frm[55] = 8'hFF; frm[56] = 8'h00; frm[57] = 8'h00;
        build_frame_fix_udp();
        send_frame();
    endtask

    // Receiver holds off while the sender keeps offering frames
    task automatic test_backpressure();
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 5; i++) begin
            build_frame(DST_LL, PROTO_UDP, 8'h00, 16, CS_GOOD, 8'h00, 16, 1);
            send_frame();
        end
        drain();
    endtask

    task automatic test_random(input int min_bytes, input int min_words);
        int sent;
        int first;
        sent  = 0;
        first = words_checked + verdict_q.size();
        while (sent < min_bytes || words_checked + verdict_q.size() - first < min_words) begin
            if ($urandom_range(0, 4) == 0) random_noise_frame();
            else                           random_good_frame();
            sent += frm.size();
            send_frame();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.data    = '0;
        errors        = 0;
        words_checked = 0;
        hold_cycles   = 0;
        idle_on       = 1'b0;
        station_mac     = '0;
        last_sender_mac = '0;
        clear_frame_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value of the station MAC first, then the extremes
        test_destinations();
        write_station_mac(48'hFFFF_FFFF_FFFF);
        test_destinations();
        write_station_mac(48'({$urandom, $urandom}));
        test_header_errors();
        test_icmp();
        test_udp();

        idle_on = 1'b1;
        test_backpressure();
        test_random(500, 30);
        write_station_mac(48'h0);
        test_random(300, 20);
        write_station_mac(48'({$urandom, $urandom}));
        test_random(300, 20);
        // Final stretch runs at full rate
        idle_on = 1'b0;
        test_random(300, 20);

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ipv6rfc_pkg.sv
hw/rtl/ipv6rfc_if.sv
hw/rtl/ipv6_receive_frame_classifier.sv
hw/rtl/ipv6rfc_checker.sv
dv/testbench.sv
